>>> rtl/serial_weight_line_parser_top_macros.svh
// Assertion macros shared by the serial weight line parser modules.
`ifndef SERIAL_WEIGHT_LINE_PARSER_TOP_MACROS_SVH
`define SERIAL_WEIGHT_LINE_PARSER_TOP_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define SWLP_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("swlp assertion failed: condition");

// Antecedent in one cycle implies consequent in the next.
`define SWLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swlp assertion failed: next-cycle implication");

`endif

>>> rtl/swlp_pkg.sv
// Types and constants shared by the serial weight line parser.
package swlp_pkg;

  localparam int LINE_MAX    = 128;
  localparam int CHAR_W      = 8;
  localparam int MAG_W       = 30;
  localparam int MILLI_W     = 31;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] LINE_MAX_C = CHAR_W'(LINE_MAX);
  localparam logic [MAG_W-1:0]  MAG_CAP    = MAG_W'(999999999);

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef logic [2:0] tok_kind_t;
  localparam tok_kind_t TK_OTHER = 3'd0;
  localparam tok_kind_t TK_DIGIT = 3'd1;
  localparam tok_kind_t TK_PLUS  = 3'd2;
  localparam tok_kind_t TK_MINUS = 3'd3;
  localparam tok_kind_t TK_MARK  = 3'd4;
  localparam tok_kind_t TK_TERM  = 3'd5;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
  } tok_t;

endpackage

>>> rtl/swlp_front.sv
// Byte classifier: turns a received byte into a scanner token.
module swlp_front
  import swlp_pkg::*;
(
  input  logic [7:0] rx_byte,
  output tok_t       tok
);

  logic is_digit;
  logic [7:0] digit_full;

  assign is_digit   = (rx_byte >= CH_0) && (rx_byte <= CH_9);
  assign digit_full = rx_byte - CH_0;

  always_comb begin
    tok.digit = is_digit ? digit_full[3:0] : 4'd0;
    if (is_digit) begin
      tok.kind = TK_DIGIT;
    end else begin
      unique case (rx_byte) inside
        CH_PLUS:          tok.kind = TK_PLUS;
        CH_MINUS:         tok.kind = TK_MINUS;
        CH_DOT, CH_COMMA: tok.kind = TK_MARK;
        CH_LF, CH_CR:     tok.kind = TK_TERM;
        default:          tok.kind = TK_OTHER;
      endcase
    end
  end

endmodule

>>> rtl/swlp_queue.sv
// Small token queue between the classifier and the scanner.
`include "serial_weight_line_parser_top_macros.svh"
module swlp_queue
  import swlp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output tok_t head_tok
);

  tok_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;

  assign full      = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_tok  = mem_r[rd_ptr_r];

  function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
    return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  `SWLP_ASSERT_ALWAYS(a_count_bound, count_r <= QUEUE_CW'(QUEUE_DEPTH))
  `SWLP_ASSERT_ALWAYS(a_no_push_full, !(push && full && !pop))
  `SWLP_ASSERT_ALWAYS(a_no_pop_empty, !(pop && !not_empty))
  `SWLP_ASSERT_NEXT(a_push_fills, push && !pop, not_empty)

endmodule

>>> rtl/swlp_back.sv
// Line scanner: number parsing, line framing and the result register.
`include "serial_weight_line_parser_top_macros.svh"
module swlp_back
  import swlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tok_valid,
  input  tok_t               tok,
  output logic               tok_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_weight_found,
  output logic [MILLI_W-1:0] out_weight_milli,
  output logic [CHAR_W-1:0]  out_line_chars
);

  localparam logic [1:0] PH_SEEK = 2'd0;
  localparam logic [1:0] PH_INT  = 2'd1;
  localparam logic [1:0] PH_FRAC = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam int SUM_W = MAG_W + 4;

  logic [1:0]        phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  logic              seen_r, seen_nxt;
  logic [MAG_W-1:0]  acc_r, acc_nxt;
  logic [2:0]        fdig_r, fdig_nxt;
  logic [3:0]        rdig_r, rdig_nxt;
  logic [CHAR_W-1:0] cnt_r, cnt_nxt;

  logic               ovalid_r, ovalid_nxt;
  logic               ofound_r;
  logic [MILLI_W-1:0] omilli_r;
  logic [CHAR_W-1:0]  ochars_r;

  logic [SUM_W-1:0]   int_sum, frac_sum;
  logic [MAG_W-1:0]   int_cap, frac_cap;
  logic [MAG_W-1:0]   mag_base, mag_final;
  logic [MILLI_W-1:0] milli_val;
  logic               emit;

  assign tok_pop = tok_valid && (!ovalid_r || !out_stall);

  always_comb begin
    int_sum = SUM_W'(acc_r) * SUM_W'(10) + SUM_W'(tok.digit) * SUM_W'(1000);
    unique case (fdig_r)
      3'd0:    frac_sum = SUM_W'(acc_r) + SUM_W'(tok.digit) * SUM_W'(100);
      3'd1:    frac_sum = SUM_W'(acc_r) + SUM_W'(tok.digit) * SUM_W'(10);
      3'd2:    frac_sum = SUM_W'(acc_r) + SUM_W'(tok.digit);
      default: frac_sum = SUM_W'(acc_r);
    endcase
    int_cap  = (int_sum > SUM_W'(MAG_CAP)) ? MAG_CAP : int_sum[MAG_W-1:0];
    frac_cap = (frac_sum > SUM_W'(MAG_CAP)) ? MAG_CAP : frac_sum[MAG_W-1:0];
  end

  always_comb begin
    mag_base  = seen_r ? acc_r : '0;
    mag_final = mag_base;
    if (seen_r && (rdig_r >= 4'd5) && (mag_base != MAG_CAP)) begin
      mag_final = mag_base + 1'b1;
    end
    if (neg_r && (mag_final != '0)) begin
      milli_val = MILLI_W'(~{1'b0, mag_final}) + 1'b1;
    end else begin
      milli_val = {1'b0, mag_final};
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    seen_nxt  = seen_r;
    acc_nxt   = acc_r;
    fdig_nxt  = fdig_r;
    rdig_nxt  = rdig_r;
    cnt_nxt   = cnt_r;
    emit      = 1'b0;
    if (tok_pop) begin
      if (tok.kind == TK_TERM) begin
        if (cnt_r != '0) begin
          emit      = 1'b1;
          phase_nxt = PH_SEEK;
          neg_nxt   = 1'b0;
          seen_nxt  = 1'b0;
          acc_nxt   = '0;
          fdig_nxt  = '0;
          rdig_nxt  = '0;
          cnt_nxt   = '0;
        end
      end else if (cnt_r >= LINE_MAX_C) begin
        phase_nxt = PH_SEEK;
        neg_nxt   = 1'b0;
        seen_nxt  = 1'b0;
        acc_nxt   = '0;
        fdig_nxt  = '0;
        rdig_nxt  = '0;
        cnt_nxt   = '0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        unique case (phase_r)
          PH_SEEK: begin
            unique case (tok.kind)
              TK_DIGIT: begin
                phase_nxt = PH_INT;
                seen_nxt  = 1'b1;
                acc_nxt   = int_cap;
              end
              TK_PLUS:  phase_nxt = PH_INT;
              TK_MINUS: begin
                phase_nxt = PH_INT;
                neg_nxt   = 1'b1;
              end
              default: ;
            endcase
          end
          PH_INT: begin
            unique case (tok.kind)
              TK_DIGIT: begin
                seen_nxt = 1'b1;
                acc_nxt  = int_cap;
              end
              TK_MARK: phase_nxt = PH_FRAC;
              default: phase_nxt = PH_DONE;
            endcase
          end
          PH_FRAC: begin
            if (tok.kind == TK_DIGIT) begin
              seen_nxt = 1'b1;
              acc_nxt  = frac_cap;
              if (fdig_r == 3'd3) begin
                rdig_nxt = tok.digit;
              end
              if (fdig_r < 3'd4) begin
                fdig_nxt = fdig_r + 1'b1;
              end
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
    end else if (!out_stall) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEEK;
      neg_r    <= 1'b0;
      seen_r   <= 1'b0;
      acc_r    <= '0;
      fdig_r   <= '0;
      rdig_r   <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      seen_r   <= seen_nxt;
      acc_r    <= acc_nxt;
      fdig_r   <= fdig_nxt;
      rdig_r   <= rdig_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ofound_r <= seen_r;
      omilli_r <= milli_val;
      ochars_r <= cnt_r;
    end
  end

  assign out_valid        = ovalid_r;
  assign out_weight_found = ofound_r;
  assign out_weight_milli = omilli_r;
  assign out_line_chars   = ochars_r;

  `SWLP_ASSERT_ALWAYS(a_notfound_zero, !ovalid_r || ofound_r || (omilli_r == '0))
  `SWLP_ASSERT_ALWAYS(a_chars_range, !ovalid_r || ((ochars_r != '0) && (ochars_r <= LINE_MAX_C)))
  `SWLP_ASSERT_ALWAYS(a_seek_clean, (phase_r != PH_SEEK) || (!seen_r && !neg_r))
  `SWLP_ASSERT_ALWAYS(a_acc_cap, acc_r <= MAG_CAP)
  `SWLP_ASSERT_NEXT(a_emit_valid, emit, ovalid_r)

endmodule

>>> rtl/serial_weight_line_parser_top.sv
// Top level of the serial weight line parser.
// Accepts one received byte per clock cycle while in_stall is low. A two-entry
// token queue sits between the byte classifier and the line scanner, so input
// keeps flowing for up to two bytes while a result waits on out_stall. The
// scanner retires one byte per cycle while no result waits on out_stall; with
// the queue empty and the output free, out_valid rises at the clock edge after
// the one that accepts the CR or LF byte ending the line. Empty lines give no
// result; at its 129th character a line is dropped and counting starts anew.
module serial_weight_line_parser_top
  import swlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_weight_found,
  output logic [MILLI_W-1:0] out_weight_milli,
  output logic [CHAR_W-1:0]  out_line_chars
);

  tok_t in_tok;
  tok_t head_tok;
  logic q_full;
  logic q_not_empty;
  logic q_pop;
  logic q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  swlp_front u_front (
    .rx_byte (in_rx_byte),
    .tok     (in_tok)
  );

  swlp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (in_tok),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_tok  (head_tok)
  );

  swlp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .tok_valid        (q_not_empty),
    .tok              (head_tok),
    .tok_pop          (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_weight_found (out_weight_found),
    .out_weight_milli (out_weight_milli),
    .out_line_chars   (out_line_chars)
  );

endmodule

>>> bench/weight_line_checker.sv
// Scoreboard for the serial weight line parser: predicts line results and compares them.
module weight_line_checker
  import swlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_weight_found,
  input  logic [MILLI_W-1:0] out_weight_milli,
  input  logic [CHAR_W-1:0]  out_line_chars,
  output int                 fail_count,
  output int                 lines_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {SEEK_START, INT_DIGITS, FRAC_DIGITS, NUM_DONE} scan_phase_e;

  typedef struct packed {
    logic               found;
    logic [MILLI_W-1:0] milli;
    logic [CHAR_W-1:0]  chars;
  } line_result_t;

  line_result_t lines_due[$];

  scan_phase_e        phase;
  logic               neg;
  logic               seen;
  logic [MAG_W-1:0]   mag;
  logic [2:0]         frac_n;
  logic [3:0]         rnd;
  logic [CHAR_W-1:0]  nchars;

  function automatic logic [MAG_W-1:0] capped(longint unsigned v);
    return (v > MAG_CAP) ? MAG_CAP : MAG_W'(v);
  endfunction

  task automatic clear_line_state();
    phase  = SEEK_START;
    neg    = 1'b0;
    seen   = 1'b0;
    mag    = '0;
    frac_n = '0;
    rnd    = '0;
    nchars = '0;
  endtask

  task automatic take_int_digit(logic [3:0] d);
    seen = 1'b1;
    mag  = capped(longint'(mag) * 10 + longint'(d) * 1000);
  endtask

  task automatic take_frac_digit(logic [3:0] d);
    seen = 1'b1;
    case (frac_n)
      3'd0: mag = capped(longint'(mag) + longint'(d) * 100);
      3'd1: mag = capped(longint'(mag) + longint'(d) * 10);
      3'd2: mag = capped(longint'(mag) + longint'(d));
      3'd3: rnd = d;
      default: ;
    endcase
    if (frac_n < 3'd4) frac_n = frac_n + 3'd1;
  endtask

  task automatic scan_char(logic [7:0] b);
    logic       is_digit;
    logic [3:0] d;
    is_digit = (b >= CH_0) && (b <= CH_9);
    d = is_digit ? 4'(b - CH_0) : 4'd0;
    case (phase)
      SEEK_START: begin
        if (is_digit) begin
          phase = INT_DIGITS;
          take_int_digit(d);
        end else if (b == CH_PLUS) begin
          phase = INT_DIGITS;
        end else if (b == CH_MINUS) begin
          phase = INT_DIGITS;
          neg = 1'b1;
        end
      end
      INT_DIGITS: begin
        if (is_digit) take_int_digit(d);
        else if (b == CH_DOT || b == CH_COMMA) phase = FRAC_DIGITS;
        else phase = NUM_DONE;
      end
      FRAC_DIGITS: begin
        if (is_digit) take_frac_digit(d);
        else phase = NUM_DONE;
      end
      default: ;
    endcase
  endtask

  task automatic absorb_byte(input logic [7:0] b, output bit emit, output line_result_t r);
    logic [MAG_W-1:0] m;
    emit = 1'b0;
    r = '0;
    if (b == CH_LF || b == CH_CR) begin
      if (nchars != 0) begin
        m = seen ? mag : '0;
        if (seen && rnd >= 4'd5) m = capped(longint'(m) + 1);
        r.found = seen;
        r.milli = (neg && m != 0) ? MILLI_W'(0) - MILLI_W'(m) : MILLI_W'(m);
        r.chars = nchars;
        emit = 1'b1;
        clear_line_state();
      end
    end else if (nchars >= LINE_MAX_C) begin
      clear_line_state();
    end else begin
      nchars = nchars + 1'b1;
      scan_char(b);
    end
  endtask

  always @(posedge clk) begin
    line_result_t got;
    line_result_t want;
    line_result_t made;
    bit           emit;
    if (!rst_n) begin
      clear_line_state();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_weight_found, out_weight_milli, out_line_chars};
        if (lines_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result found=%0b milli=%0d chars=%0d", $realtime,
                     got.found, $signed(got.milli), got.chars);
          fail_count++;
        end else begin
          want = lines_due.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp found=%0b milli=%0d chars=%0d, got found=%0b milli=%0d chars=%0d",
                       $realtime, want.found, $signed(want.milli), want.chars,
                       got.found, $signed(got.milli), got.chars);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        absorb_byte(in_rx_byte, emit, made);
        if (emit) lines_due.push_back(made);
      end
    end
    lines_pending <= lines_due.size();
  end

endmodule

>>> bench/testbench.sv
// Top of the serial weight line parser bench: clock, reset, byte stimulus and verdict.
module testbench
  import swlp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1700;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic               out_weight_found;
  logic [MILLI_W-1:0] out_weight_milli;
  logic [CHAR_W-1:0]  out_line_chars;

  int fail_count;
  int lines_pending;
  int cycle_count = 0;
  int bytes_sent = 0;
  int results_taken = 0;
  int calm_in = 0;
  int calm_out = 0;

  logic [7:0] tx_line[$];

  serial_weight_line_parser_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_weight_found (out_weight_found),
    .out_weight_milli (out_weight_milli),
    .out_line_chars   (out_line_chars)
  );

  weight_line_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_weight_found (out_weight_found),
    .out_weight_milli (out_weight_milli),
    .out_line_chars   (out_line_chars),
    .fail_count       (fail_count),
    .lines_pending    (lines_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    if (calm_in > 0) begin
      calm_in--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 63) == 0) calm_in = $urandom_range(20, 80);
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic push_digit();
    tx_line.push_back(CH_0 + 8'($urandom_range(0, 9)));
  endtask

  task automatic make_random_line();
    int kind;
    kind = $urandom_range(0, 99);
    tx_line = {};
    if (kind < 60) begin
      repeat ($urandom_range(0, 3))
        tx_line.push_back($urandom_range(0, 3) == 0 ? 8'h20 : 8'($urandom_range(8'h41, 8'h5A)));
      case ($urandom_range(0, 3))
        0: tx_line.push_back(CH_PLUS);
        1: tx_line.push_back(CH_MINUS);
        default: ;
      endcase
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4))
        push_digit();
      if ($urandom_range(0, 2) != 0) begin
        tx_line.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
        repeat ($urandom_range(0, 6)) push_digit();
      end
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: tx_line.push_back(CH_PLUS);
          1: tx_line.push_back(CH_MINUS);
          2: tx_line.push_back(CH_DOT);
          default: tx_line.push_back(CH_COMMA);
        endcase
        repeat ($urandom_range(1, 3)) push_digit();
      end
      if ($urandom_range(0, 1)) begin
        tx_line.push_back(8'h20);
        tx_line.push_back(8'h6B);
        tx_line.push_back(8'h67);
      end
    end else if (kind < 68) begin
      // values around the saturation bound
      if ($urandom_range(0, 1)) tx_line.push_back(CH_MINUS);
      repeat ($urandom_range(5, 8)) tx_line.push_back(CH_9);
      tx_line.push_back(CH_DOT);
      repeat (3) tx_line.push_back(CH_9);
      push_digit();
    end else if (kind < 88) begin
      repeat ($urandom_range(1, 20)) tx_line.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 96) begin
      repeat ($urandom_range(0, 2)) tx_line.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end else begin
      // around the line length limit
      repeat ($urandom_range(LINE_MAX - 6, LINE_MAX + 10))
        tx_line.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end
    case ($urandom_range(0, 2))
      0: tx_line.push_back(CH_CR);
      1: tx_line.push_back(CH_LF);
      default: begin
        tx_line.push_back(CH_CR);
        tx_line.push_back(CH_LF);
      end
    endcase
  endtask

  // result side: random stall per item, two long hold-offs to back up the input
  initial begin
    int hold;
    out_stall <= 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_taken == 15 || results_taken == 90) begin
        hold = 300;
      end else if (calm_out > 0) begin
        calm_out--;
        hold = 0;
      end else begin
        if ($urandom_range(0, 31) == 0) calm_out = $urandom_range(10, 40);
        hold = $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // negative zero, then CRLF giving one result
    send_text("-0.0004");
    send_byte(CH_CR);
    send_byte(CH_LF);
    // sign and mark without digits
    send_text("+.");
    send_byte(CH_LF);
    // extra fraction digits, second sign ends the number
    send_text("1,23456-7");
    send_byte(CH_CR);
    // byte extremes count as line characters
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_LF);

    while (bytes_sent < ITEM_TARGET) begin
      make_random_line();
      foreach (tx_line[i]) send_byte(tx_line[i]);
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (lines_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && lines_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> serial_weight_line_parser_top.f
+incdir+rtl
rtl/swlp_pkg.sv
rtl/swlp_front.sv
rtl/swlp_queue.sv
rtl/swlp_back.sv
rtl/serial_weight_line_parser_top.sv
bench/weight_line_checker.sv
bench/testbench.sv
